[hdl/mra_pkg.sv]
// Shared types and constants of the multichannel running average block.
// Used by every module of the block; depends on nothing.
package mra_pkg;

  localparam int CHAN_BITS   = 4;
  localparam int SAMPLE_BITS = 10;
  localparam int LIMIT_BITS  = 8;
  localparam int SUM_BITS    = SAMPLE_BITS + LIMIT_BITS + 1;
  localparam int ACC_BITS    = SUM_BITS + 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET = LIMIT_BITS'(16);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX  = '1;
  localparam logic [SUM_BITS-1:0]    SUM_MAX     = '1;

  typedef struct packed {
    logic [CHAN_BITS-1:0]   channel;
    logic [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0]   out_channel;
    logic [SAMPLE_BITS-1:0] average;
    logic [LIMIT_BITS-1:0]  count;
  } out_item_t;

  // Work item queued between the front and the back.
  typedef struct packed {
    logic [CHAN_BITS-1:0]   channel;
    logic [SAMPLE_BITS-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CALC,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

[hdl/mra_front.sv]
// Front end: accepts samples, drops those for channels that do not exist,
// and queues the rest. Depends on mra_pkg.
module mra_front #(
  parameter int CHANNELS = 10
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mra_pkg::in_item_t     in_data,
  input  mra_pkg::fifo_status_t status,
  output logic                  push,
  output mra_pkg::cmd_t         push_data
);
  import mra_pkg::*;

  logic in_range;

  assign in_range  = {1'b0, in_data.channel} < (CHAN_BITS + 1)'(CHANNELS);
  assign in_ready  = !status.full;
  // A transfer for a channel out of range is taken and discarded.
  assign push      = in_valid && in_ready && in_range;
  assign push_data = '{channel: in_data.channel, sample: in_data.sample};

endmodule

[hdl/mra_fifo.sv]
// Short command queue between the front and the back.
// Depends on mra_pkg.
module mra_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mra_pkg::cmd_t         push_data,
  input  logic                  pop,
  output mra_pkg::cmd_t         pop_data,
  output mra_pkg::fifo_status_t status
);
  import mra_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  cmd_t                entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;
  logic                do_push;
  logic                do_pop;

  assign status.full  = fill == CNT_BITS'(DEPTH);
  assign status.empty = fill == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[hdl/mra_back.sv]
// Back end: per-channel sum, count and average state, a bit-serial
// restoring divider and the result register. Depends on mra_pkg.
module mra_back #(
  parameter int CHANNELS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mra_pkg::LIMIT_BITS-1:0]      cfg_data,
  input  mra_pkg::fifo_status_t               status,
  output logic                                pop,
  input  mra_pkg::cmd_t                       pop_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mra_pkg::out_item_t                  out_data
);
  import mra_pkg::*;

  localparam int IDX_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STEP_BITS = $clog2(SUM_BITS + 1);

  back_state_t state;
  back_state_t state_next;
  logic        commit;

  logic [LIMIT_BITS-1:0]  limit;
  logic [SUM_BITS-1:0]    sum_mem [CHANNELS];
  logic [LIMIT_BITS-1:0]  cnt_mem [CHANNELS];
  logic [SAMPLE_BITS-1:0] avg_mem [CHANNELS];

  cmd_t                   cmd;
  logic [IDX_BITS-1:0]    idx;
  logic [SUM_BITS-1:0]    cur_sum;
  logic [LIMIT_BITS-1:0]  cur_cnt;
  logic [SAMPLE_BITS-1:0] cur_avg;
  logic [LIMIT_BITS:0]    cnt_inc;
  logic                   over;
  logic [ACC_BITS-1:0]    acc;
  logic [SUM_BITS-1:0]    sum_clamped;
  logic [LIMIT_BITS-1:0]  cnt_new;

  logic [SUM_BITS-1:0]    sum_r;
  logic [LIMIT_BITS-1:0]  cnt_r;
  logic [SAMPLE_BITS-1:0] avg_old;
  logic [LIMIT_BITS-1:0]  rem;
  logic [LIMIT_BITS-1:0]  rem_next;
  logic [SUM_BITS-1:0]    quo;
  logic [SUM_BITS-1:0]    quo_next;
  logic [STEP_BITS-1:0]   step;
  logic [LIMIT_BITS:0]    trial;
  logic [LIMIT_BITS:0]    diff;
  logic                   fits;
  logic [SAMPLE_BITS-1:0] avg_new;

  assign idx     = cmd.channel[IDX_BITS-1:0];
  assign cur_sum = sum_mem[idx];
  assign cur_cnt = cnt_mem[idx];
  assign cur_avg = avg_mem[idx];

  // Update of sum and count; the sum is clamped to its range on both ends.
  always_comb begin
    cnt_inc = {1'b0, cur_cnt} + (LIMIT_BITS + 1)'(1);
    over    = cnt_inc > {1'b0, limit};
    acc     = ACC_BITS'(cur_sum) + ACC_BITS'(cmd.sample)
            - (over ? ACC_BITS'(cur_avg) : ACC_BITS'(0));
    if (acc[ACC_BITS-1]) begin
      sum_clamped = '0;
    end else if (|acc[ACC_BITS-2:SUM_BITS]) begin
      sum_clamped = SUM_MAX;
    end else begin
      sum_clamped = acc[SUM_BITS-1:0];
    end
    cnt_new = over ? limit : cnt_inc[LIMIT_BITS-1:0];
  end

  // One quotient bit per cycle, most significant first.
  always_comb begin
    trial    = {rem, quo[SUM_BITS-1]};
    diff     = trial - {1'b0, cnt_r};
    fits     = trial >= {1'b0, cnt_r};
    rem_next = fits ? diff[LIMIT_BITS-1:0] : trial[LIMIT_BITS-1:0];
    quo_next = {quo[SUM_BITS-2:0], fits};
  end

  always_comb begin
    if (cnt_r == '0) begin
      avg_new = avg_old;
    end else if (|quo[SUM_BITS-1:SAMPLE_BITS]) begin
      avg_new = SAMPLE_MAX;
    end else begin
      avg_new = quo[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    commit     = 1'b0;
    case (state)
      B_IDLE: begin
        if (!status.empty) begin
          pop        = 1'b1;
          state_next = B_CALC;
        end
      end
      B_CALC: begin
        state_next = (cnt_new == '0) ? B_DONE : B_DIV;
      end
      B_DIV: begin
        if (step == STEP_BITS'(1)) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid || out_ready) begin
          commit     = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      limit     <= LIMIT_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_mem[i] <= '0;
        cnt_mem[i] <= '0;
        avg_mem[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        limit <= cfg_data;
      end
      if (commit) begin
        sum_mem[idx] <= sum_r;
        cnt_mem[idx] <= cnt_r;
        avg_mem[idx] <= avg_new;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= pop_data;
    end
    if (state == B_CALC) begin
      sum_r   <= sum_clamped;
      cnt_r   <= cnt_new;
      avg_old <= cur_avg;
      rem     <= '0;
      quo     <= sum_clamped;
      step    <= STEP_BITS'(SUM_BITS);
    end else if (state == B_DIV) begin
      rem  <= rem_next;
      quo  <= quo_next;
      step <= step - 1'b1;
    end
    if (commit) begin
      out_data <= '{out_channel: cmd.channel, average: avg_new, count: cnt_r};
    end
  end

endmodule

[hdl/multichannel_running_average.sv]
// A sample passes the queue and the back end's calc, divide and done states, one
// sample at a time; the 19-step bit-serial divide is skipped when the count is zero.
// A four-entry queue takes samples while the divider or output is busy, until full.
// Reset is synchronous: sums, counts and averages clear, the window limit
// returns to 16 and the queue empties; no clearing pass follows.
module multichannel_running_average #(
  parameter int CHANNELS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mra_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mra_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [mra_pkg::LIMIT_BITS-1:0] cfg_data
);
  import mra_pkg::*;

  fifo_status_t status;
  logic         push;
  logic         pop;
  cmd_t         push_data;
  cmd_t         pop_data;

  mra_front #(.CHANNELS(CHANNELS)) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .status    (status),
    .push      (push),
    .push_data (push_data)
  );

  mra_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (status)
  );

  mra_back #(.CHANNELS(CHANNELS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .status    (status),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[hdl/mra_checker.sv]
// Port-level checks for the multichannel running average block, and the
// bind that attaches them to the top level. Depends on mra_pkg.
module mra_checker #(
  parameter int CHANNELS = 10
) (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input mra_pkg::out_item_t out_data
);
  import mra_pkg::*;

  // A stalled result keeps its place and its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  // Samples for missing channels never produce a result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, out_data.out_channel} < (CHAN_BITS + 1)'(CHANNELS))
    else $error("result for a channel that does not exist");

  // After reset no result is pending and the queue has room.
  assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("reset left a result pending or the queue full");

endmodule

bind multichannel_running_average mra_checker #(.CHANNELS(CHANNELS)) u_mra_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// Testbench for multichannel_running_average: drives tagged samples and limit writes,
// predicts each channel's sum, count and average, and checks every result transfer.
// Depends on mra_pkg and the multichannel_running_average RTL.
module tb;
  import mra_pkg::*;

  localparam int CHANNELS      = 10;
  localparam int SETTLE_CYCLES = 40;
  localparam int BACKLOG_HOLD  = 400;

  typedef enum bit {
    ROW_SAMPLE,
    ROW_LIMIT
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    in_item_t              data;
    logic [LIMIT_BITS-1:0] limit;
    bit                    typed;
    out_item_t             result;
  } stim_row_t;

  typedef struct packed {
    bit        typed;
    out_item_t result;
  } row_check_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [LIMIT_BITS-1:0] cfg_data = '0;

  // Per-channel state of the averaging model.
  logic [SUM_BITS-1:0]    chan_sum [CHANNELS];
  logic [LIMIT_BITS-1:0]  chan_count [CHANNELS];
  logic [SAMPLE_BITS-1:0] chan_average [CHANNELS];
  logic [LIMIT_BITS-1:0]  limit_model;

  row_check_t row_checks [$];
  out_item_t  awaited_averages [$];
  int         failures = 0;
  int         burst_left = 0;
  bit         steady_sender = 1'b0;
  bit         hold_backlog = 1'b0;

  // Special cases: ignored channels, limit of zero with the sum clamped at zero,
  // and a limit lowered below the count, which saturates the average.
  stim_row_t directed_rows [0:19] = '{
    '{ROW_SAMPLE, '{4'd0,  10'd1023}, 8'd0,   1'b1, '{4'd0, 10'd1023, 8'd1}},
    '{ROW_SAMPLE, '{4'd0,  10'd0},    8'd0,   1'b0, '0},
    '{ROW_SAMPLE, '{4'd15, 10'd1023}, 8'd0,   1'b0, '0},
    '{ROW_SAMPLE, '{4'd10, 10'd0},    8'd0,   1'b0, '0},
    '{ROW_SAMPLE, '{4'd9,  10'd0},    8'd0,   1'b1, '{4'd9, 10'd0, 8'd1}},
    '{ROW_SAMPLE, '{4'd5,  10'd682},  8'd0,   1'b1, '{4'd5, 10'd682, 8'd1}},
    '{ROW_SAMPLE, '{4'd6,  10'd341},  8'd0,   1'b1, '{4'd6, 10'd341, 8'd1}},
    '{ROW_LIMIT,  '0,                 8'd0,   1'b0, '0},
    '{ROW_SAMPLE, '{4'd0,  10'd0},    8'd0,   1'b0, '0},
    '{ROW_SAMPLE, '{4'd1,  10'd0},    8'd0,   1'b1, '{4'd1, 10'd0, 8'd0}},
    '{ROW_SAMPLE, '{4'd0,  10'd0},    8'd0,   1'b0, '0},
    '{ROW_SAMPLE, '{4'd0,  10'd0},    8'd0,   1'b0, '0},
    '{ROW_LIMIT,  '0,                 8'd255, 1'b0, '0},
    '{ROW_SAMPLE, '{4'd3,  10'd1023}, 8'd0,   1'b1, '{4'd3, 10'd1023, 8'd1}},
    '{ROW_SAMPLE, '{4'd3,  10'd1023}, 8'd0,   1'b0, '0},
    '{ROW_SAMPLE, '{4'd3,  10'd1023}, 8'd0,   1'b0, '0},
    '{ROW_LIMIT,  '0,                 8'd1,   1'b0, '0},
    '{ROW_SAMPLE, '{4'd3,  10'd1023}, 8'd0,   1'b1, '{4'd3, 10'd1023, 8'd1}},
    '{ROW_SAMPLE, '{4'd4,  10'd1},    8'd0,   1'b1, '{4'd4, 10'd1, 8'd1}},
    '{ROW_LIMIT,  '0,                 8'd16,  1'b0, '0}
  };

  logic [LIMIT_BITS-1:0] phase_limits [0:7] = '{8'd2, 8'd128, 8'd7, 8'd1, 8'd200, 8'd0,
                                                 8'd16, 8'd255};

  multichannel_running_average #(
    .CHANNELS(CHANNELS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Updates one channel for an accepted sample; returns 0 when the channel is ignored.
  function automatic bit advance_channel(input in_item_t item, output out_item_t result);
    longint acc;
    longint next_count;
    longint quotient;
    int     ch;
    result = '0;
    ch = int'(item.channel);
    if (ch >= CHANNELS) return 1'b0;
    acc = longint'(chan_sum[ch]) + longint'(item.sample);
    next_count = longint'(chan_count[ch]) + 1;
    if (next_count > longint'(limit_model)) begin
      next_count = longint'(limit_model);
      acc -= longint'(chan_average[ch]);
    end
    if (acc < 0) acc = 0;
    else if (acc > longint'(SUM_MAX)) acc = longint'(SUM_MAX);
    if (next_count != 0) begin
      quotient = acc / next_count;
      chan_average[ch] = (quotient > longint'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                           : SAMPLE_BITS'(quotient);
    end
    chan_sum[ch] = SUM_BITS'(acc);
    chan_count[ch] = LIMIT_BITS'(next_count);
    result = '{item.channel, chan_average[ch], LIMIT_BITS'(next_count)};
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SAMPLE_MAX;
      default: return SAMPLE_BITS'($urandom_range(0, int'(SAMPLE_MAX)));
    endcase
  endfunction

  // Mostly valid channels; about one transfer in eight may carry any channel code.
  function automatic in_item_t random_item();
    in_item_t item;
    if ($urandom_range(0, 7) == 0) item.channel = CHAN_BITS'($urandom_range(0, 15));
    else item.channel = CHAN_BITS'($urandom_range(0, CHANNELS - 1));
    item.sample = random_sample();
    return item;
  endfunction

  always @(posedge clk) begin
    row_check_t check;
    out_item_t  predicted;
    out_item_t  want;
    if (rst) begin
      limit_model = LIMIT_RESET;
      foreach (chan_sum[c]) begin
        chan_sum[c] = '0;
        chan_count[c] = '0;
        chan_average[c] = '0;
      end
    end else begin
      if (cfg_we) limit_model = cfg_data;
      if (in_valid && in_ready) begin
        check = row_checks.pop_front();
        if (advance_channel(in_data, predicted))
          awaited_averages.push_back(check.typed ? check.result : predicted);
      end
      if (out_valid && out_ready) begin
        if (awaited_averages.size() == 0) begin
          $error("result transfer on channel %0d with nothing expected",
                 out_data.out_channel);
          failures++;
        end else begin
          want = awaited_averages.pop_front();
          if (out_data.out_channel !== want.out_channel) begin
            $error("out_channel: expected %0d, got %0d", want.out_channel,
                   out_data.out_channel);
            failures++;
          end
          if (out_data.average !== want.average) begin
            $error("average: expected %0d, got %0d", want.average, out_data.average);
            failures++;
          end
          if (out_data.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_data.count);
            failures++;
          end
        end
      end
    end
  end

  // Receiver: stall segments of random style and length, plus one long hold-off on request.
  initial begin : receiver
    int mode;
    int left;
    int cycle;
    mode = 0;
    left = 0;
    cycle = 0;
    forever begin
      @(posedge clk);
      if (hold_backlog) begin
        out_ready <= 1'b0;
        repeat (BACKLOG_HOLD) @(posedge clk);
        hold_backlog = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 300);
      end
      left--;
      cycle++;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((cycle % 8) < 5);
      endcase
    end
  end

  // Offers one sample, waits for the edge where it transfers, then may insert a burst gap.
  task automatic offer(input in_item_t item, input bit typed = 1'b0,
                       input out_item_t result = '0);
    int gap;
    row_checks.push_back('{typed, result});
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !steady_sender) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 48);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Waits until every expected result has arrived and ignored samples have left the block.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    in_item_t item;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_LIMIT) write_limit(directed_rows[r].limit);
      else offer(directed_rows[r].data, directed_rows[r].typed, directed_rows[r].result);
    end

    // Empty channel 9 with a limit of one, then let its sum run into the top clamp.
    write_limit(8'd1);
    repeat (24) offer('{4'd9, 10'd0});
    write_limit(8'd0);
    repeat (640) begin
      if ($urandom_range(0, 9) != 0) begin
        item.channel = 4'd9;
        item.sample = SAMPLE_BITS'($urandom_range(1000, int'(SAMPLE_MAX)));
      end else begin
        item = random_item();
      end
      offer(item);
    end

    // Two busy channels so that the count reaches the widest limit.
    write_limit(8'd255);
    repeat (600) begin
      item = random_item();
      if ($urandom_range(0, 15) != 0) item.channel = CHAN_BITS'($urandom_range(0, 1));
      offer(item);
    end

    foreach (phase_limits[p]) begin
      write_limit((p == 7) ? LIMIT_BITS'($urandom_range(0, 255)) : phase_limits[p]);
      if (p == 1) begin
        // Long output stall with a gapless sender so that the input backs up.
        steady_sender = 1'b1;
        hold_backlog = 1'b1;
      end
      repeat (100) offer(random_item());
      steady_sender = 1'b0;
    end

    drain();
    if (failures == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
hdl/mra_pkg.sv
hdl/mra_front.sv
hdl/mra_fifo.sv
hdl/mra_back.sv
hdl/multichannel_running_average.sv
hdl/mra_checker.sv
verif/tb.sv
